// File: rtl/atrp_pkg.sv
// Shared types, constants and arithmetic helpers for the accelerometer tilt block.
package atrp_pkg;

  // Default parameter values.
  localparam int ANGLE_FRAC_BITS_DEF = 8;
  localparam int CORDIC_STAGES_DEF   = 16;

  // Fixed widths of the sample and result fields.
  localparam int IN_W    = 16;
  localparam int ROLL_W  = 17;
  localparam int PITCH_W = 16;

  // Internal fixed-point formats.
  localparam int ANG_BITS = 20;              // angle fraction bits inside the datapath
  localparam int IN_SHIFT = 16;              // fraction bits of the vector components
  localparam int TAB_LEN  = 24;              // entries in the arctangent table
  localparam int ROOT_W   = 2 * IN_SHIFT;    // magnitude width out of the square root
  localparam int CW       = 36;              // vector component width with CORDIC growth
  localparam int ZW       = 30;              // angle accumulator width

  typedef logic signed [CW-1:0] cw_t;
  typedef logic signed [ZW-1:0] ang_t;

  localparam ang_t DEG180 = ang_t'(180 << ANG_BITS);
  localparam ang_t DEG90  = ang_t'(90 << ANG_BITS);

  // One vector under rotation plus its accumulated angle.
  typedef struct packed {
    cw_t  x;
    cw_t  y;
    ang_t z;
  } cvec_t;

  // Sample fields that ride along the square-root chain.
  typedef struct packed {
    logic [IN_W-1:0] ax;
    logic [IN_W-1:0] ay;
    logic [IN_W-1:0] az;
    logic            yz_zero;
  } raw_side_t;

  // Flags that ride along the CORDIC chain.
  typedef struct packed {
    logic ax_pos;
    logic yz_zero;
  } tilt_side_t;

  // One finished result beat.
  typedef struct packed {
    logic [PITCH_W-1:0] pitch;
    logic [ROLL_W-1:0]  roll;
  } res_t;

  // Arctangent of 2^-idx in degrees, scaled by 2^ANG_BITS and rounded.
  function automatic ang_t atan_entry(input int idx);
    ang_t r;
    case (idx)
      0:       r = ang_t'(47185920);
      1:       r = ang_t'(27855475);
      2:       r = ang_t'(14718068);
      3:       r = ang_t'(7471121);
      4:       r = ang_t'(3750058);
      5:       r = ang_t'(1876857);
      6:       r = ang_t'(938658);
      7:       r = ang_t'(469357);
      8:       r = ang_t'(234682);
      9:       r = ang_t'(117342);
      10:      r = ang_t'(58671);
      11:      r = ang_t'(29335);
      12:      r = ang_t'(14668);
      13:      r = ang_t'(7334);
      14:      r = ang_t'(3667);
      15:      r = ang_t'(1833);
      16:      r = ang_t'(917);
      17:      r = ang_t'(458);
      18:      r = ang_t'(229);
      19:      r = ang_t'(115);
      20:      r = ang_t'(57);
      21:      r = ang_t'(29);
      22:      r = ang_t'(14);
      23:      r = ang_t'(7);
      default: r = '0;
    endcase
    return r;
  endfunction

  // One vectoring micro-rotation; a zero y component leaves the vector alone.
  function automatic cvec_t cordic_rot(input cvec_t v, input int sh, input ang_t ang);
    cw_t   xs;
    cw_t   ys;
    cvec_t r;
    xs = v.x >>> sh;
    ys = v.y >>> sh;
    r  = v;
    if (v.y > 0) begin
      r.x = v.x + ys;
      r.y = v.y - xs;
      r.z = v.z + ang;
    end else if (v.y < 0) begin
      r.x = v.x - ys;
      r.y = v.y + xs;
      r.z = v.z - ang;
    end
    return r;
  endfunction

  // Symmetric saturation of an angle.
  function automatic ang_t clamp_ang(input ang_t v, input ang_t lim);
    ang_t r;
    r = v;
    if (v > lim) begin
      r = lim;
    end else if (v < -lim) begin
      r = -lim;
    end
    return r;
  endfunction

endpackage

// File: rtl/atrp_sqrt_cell.sv
// One cell of the pipelined integer square root: settles one root bit per cycle while en is high.
module atrp_sqrt_cell #(
  parameter int ROOT_W = atrp_pkg::ROOT_W,
  parameter int SIDE_W = 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [2*ROOT_W-1:0]   in_rad,
  input  logic [ROOT_W:0]       in_rem,
  input  logic [ROOT_W-1:0]     in_root,
  input  logic [SIDE_W-1:0]     in_side,
  output logic                  out_valid,
  output logic [2*ROOT_W-1:0]   out_rad,
  output logic [ROOT_W:0]       out_rem,
  output logic [ROOT_W-1:0]     out_root,
  output logic [SIDE_W-1:0]     out_side
);

  logic                  valid_r;
  logic [2*ROOT_W-1:0]   rad_r;
  logic [ROOT_W:0]       rem_r;
  logic [ROOT_W-1:0]     root_r;
  logic [SIDE_W-1:0]     side_r;

  logic [ROOT_W+2:0]     rem_sh;
  logic [ROOT_W+2:0]     trial;
  logic [ROOT_W+2:0]     diff;
  logic                  bit_set;
  logic [2*ROOT_W-1:0]   rad_nxt;
  logic [ROOT_W:0]       rem_nxt;
  logic [ROOT_W-1:0]     root_nxt;

  // Bring down the next two radicand bits and try the next root bit.
  always_comb begin
    rem_sh   = {in_rem, in_rad[2*ROOT_W-1 -: 2]};
    trial    = {1'b0, in_root, 2'b01};
    diff     = rem_sh - trial;
    bit_set  = (rem_sh >= trial);
    rem_nxt  = bit_set ? diff[ROOT_W:0] : rem_sh[ROOT_W:0];
    root_nxt = {in_root[ROOT_W-2:0], bit_set};
    rad_nxt  = {in_rad[2*ROOT_W-3:0], 2'b00};
  end

  // Valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  // Partial root, remainder and passengers.
  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= rad_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      side_r <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_rad   = rad_r;
  assign out_rem   = rem_r;
  assign out_root  = root_r;
  assign out_side  = side_r;

endmodule

// File: rtl/atrp_cordic_cell.sv
// One CORDIC vectoring cell that turns the roll and pitch vectors by one table angle.
module atrp_cordic_cell #(
  parameter int STAGE  = 0,
  parameter int SIDE_W = 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  atrp_pkg::cvec_t       in_roll,
  input  atrp_pkg::cvec_t       in_pitch,
  input  logic [SIDE_W-1:0]     in_side,
  output logic                  out_valid,
  output atrp_pkg::cvec_t       out_roll,
  output atrp_pkg::cvec_t       out_pitch,
  output logic [SIDE_W-1:0]     out_side
);

  localparam atrp_pkg::ang_t ANG = atrp_pkg::atan_entry(STAGE);

  logic                  valid_r;
  atrp_pkg::cvec_t       roll_r;
  atrp_pkg::cvec_t       pitch_r;
  logic [SIDE_W-1:0]     side_r;
  atrp_pkg::cvec_t       roll_nxt;
  atrp_pkg::cvec_t       pitch_nxt;

  // Both lanes use the same shift and table angle.
  always_comb begin
    roll_nxt  = atrp_pkg::cordic_rot(in_roll, STAGE, ANG);
    pitch_nxt = atrp_pkg::cordic_rot(in_pitch, STAGE, ANG);
  end

  // Valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  // Rotated vectors and passengers.
  always_ff @(posedge clk) begin
    if (en) begin
      roll_r  <= roll_nxt;
      pitch_r <= pitch_nxt;
      side_r  <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_roll  = roll_r;
  assign out_pitch = pitch_r;
  assign out_side  = side_r;

endmodule

// File: rtl/accel_tilt_roll_pitch.sv
// Beat path: squares, sum, square root chain, prep stage, CORDIC chain, finish stages, output register.
// Throughput: one triple per cycle while the skid entry is free; squares, a 32-cell square root chain and a
// CORDIC chain of CORDIC_STAGES cells (at most 24) all advance together whenever the skid entry is free.
// A two-entry output buffer keeps accepting while one result waits on the output.
// Reset (synchronous, rst_n low) clears all valid flags and the output buffer.
module accel_tilt_roll_pitch #(
  parameter int ANGLE_FRAC_BITS = atrp_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_STAGES   = atrp_pkg::CORDIC_STAGES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // accel_x[15:0], accel_y[31:16], accel_z[47:32]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // roll_angle[16:0], pitch_angle[32:17], zeros[39:33]
);

  localparam int NSTG   = (CORDIC_STAGES < atrp_pkg::TAB_LEN) ? CORDIC_STAGES
                                                               : atrp_pkg::TAB_LEN;
  localparam int RSH    = atrp_pkg::ANG_BITS - ANGLE_FRAC_BITS;
  localparam int ROOT_W = atrp_pkg::ROOT_W;
  localparam int IN_W   = atrp_pkg::IN_W;
  localparam int CW     = atrp_pkg::CW;
  localparam int EXT_W  = CW - IN_W - atrp_pkg::IN_SHIFT;
  localparam int RAW_W  = $bits(atrp_pkg::raw_side_t);
  localparam int TLT_W  = $bits(atrp_pkg::tilt_side_t);
  localparam atrp_pkg::ang_t RND = atrp_pkg::ang_t'(1 << (RSH - 1));

  // Global advance: the pipeline moves whenever the skid entry is free.
  logic pipe_en;
  logic skid_valid_r;
  assign pipe_en   = !skid_valid_r;
  assign in_tready = pipe_en;

  // ---------------------------------------------------------------------
  // Stage 1: squares of y and z.
  logic                         s1_valid_r;
  logic signed [2*IN_W-1:0]     sqy_r;
  logic signed [2*IN_W-1:0]     sqz_r;
  atrp_pkg::raw_side_t          s1_side_r;
  logic signed [IN_W-1:0]       in_ax;
  logic signed [IN_W-1:0]       in_ay;
  logic signed [IN_W-1:0]       in_az;

  assign in_ax = in_tdata[IN_W-1:0];
  assign in_ay = in_tdata[2*IN_W-1:IN_W];
  assign in_az = in_tdata[3*IN_W-1:2*IN_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (pipe_en) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      sqy_r             <= in_ay * in_ay;
      sqz_r             <= in_az * in_az;
      s1_side_r.ax      <= in_ax;
      s1_side_r.ay      <= in_ay;
      s1_side_r.az      <= in_az;
      s1_side_r.yz_zero <= (in_ay == '0) && (in_az == '0);
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: y*y + z*z, never above 2^31.
  logic                         s2_valid_r;
  logic [ROOT_W-1:0]            sq_r;
  atrp_pkg::raw_side_t          s2_side_r;
  logic [ROOT_W-1:0]            sq_nxt;

  assign sq_nxt = {1'b0, sqy_r[ROOT_W-2:0]} + {1'b0, sqz_r[ROOT_W-2:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (pipe_en) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      sq_r      <= sq_nxt;
      s2_side_r <= s1_side_r;
    end
  end

  // ---------------------------------------------------------------------
  // Square root chain: floor(sqrt(sq * 2^32)), one root bit per cell.
  logic                  sr_valid [0:ROOT_W];
  logic [2*ROOT_W-1:0]   sr_rad   [0:ROOT_W];
  logic [ROOT_W:0]       sr_rem   [0:ROOT_W];
  logic [ROOT_W-1:0]     sr_root  [0:ROOT_W];
  logic [RAW_W-1:0]      sr_side  [0:ROOT_W];

  assign sr_valid[0] = s2_valid_r;
  assign sr_rad[0]   = {sq_r, {ROOT_W{1'b0}}};
  assign sr_rem[0]   = '0;
  assign sr_root[0]  = '0;
  assign sr_side[0]  = s2_side_r;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    atrp_sqrt_cell #(
      .ROOT_W (ROOT_W),
      .SIDE_W (RAW_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (pipe_en),
      .in_valid  (sr_valid[k]),
      .in_rad    (sr_rad[k]),
      .in_rem    (sr_rem[k]),
      .in_root   (sr_root[k]),
      .in_side   (sr_side[k]),
      .out_valid (sr_valid[k+1]),
      .out_rad   (sr_rad[k+1]),
      .out_rem   (sr_rem[k+1]),
      .out_root  (sr_root[k+1]),
      .out_side  (sr_side[k+1])
    );
  end

  // ---------------------------------------------------------------------
  // Prep stage: build both vectors; roll is turned half a circle when z < 0.
  atrp_pkg::raw_side_t   sr_last;
  atrp_pkg::cw_t         roll_x;
  atrp_pkg::cw_t         roll_y;
  atrp_pkg::cw_t         pitch_y;
  atrp_pkg::cvec_t       roll_nxt;
  atrp_pkg::cvec_t       pitch_nxt;
  atrp_pkg::tilt_side_t  tside_nxt;

  assign sr_last = sr_side[ROOT_W];

  always_comb begin
    roll_x  = {{EXT_W{sr_last.az[IN_W-1]}}, sr_last.az, {atrp_pkg::IN_SHIFT{1'b0}}};
    roll_y  = {{EXT_W{sr_last.ay[IN_W-1]}}, sr_last.ay, {atrp_pkg::IN_SHIFT{1'b0}}};
    pitch_y = -{{EXT_W{sr_last.ax[IN_W-1]}}, sr_last.ax, {atrp_pkg::IN_SHIFT{1'b0}}};

    roll_nxt.x = roll_x;
    roll_nxt.y = roll_y;
    roll_nxt.z = '0;
    if (roll_x < 0) begin
      roll_nxt.x = -roll_x;
      roll_nxt.y = -roll_y;
      roll_nxt.z = (roll_y >= 0) ? atrp_pkg::DEG180 : -atrp_pkg::DEG180;
    end

    pitch_nxt.x = {{(CW-ROOT_W){1'b0}}, sr_root[ROOT_W]};
    pitch_nxt.y = pitch_y;
    pitch_nxt.z = '0;

    tside_nxt.ax_pos  = !sr_last.ax[IN_W-1] && (sr_last.ax != '0);
    tside_nxt.yz_zero = sr_last.yz_zero;
  end

  logic                  cv_valid [0:NSTG];
  atrp_pkg::cvec_t       cv_roll  [0:NSTG];
  atrp_pkg::cvec_t       cv_pitch [0:NSTG];
  logic [TLT_W-1:0]      cv_side  [0:NSTG];

  logic                  pr_valid_r;
  atrp_pkg::cvec_t       pr_roll_r;
  atrp_pkg::cvec_t       pr_pitch_r;
  atrp_pkg::tilt_side_t  pr_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pr_valid_r <= 1'b0;
    end else if (pipe_en) begin
      pr_valid_r <= sr_valid[ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      pr_roll_r  <= roll_nxt;
      pr_pitch_r <= pitch_nxt;
      pr_side_r  <= tside_nxt;
    end
  end

  assign cv_valid[0] = pr_valid_r;
  assign cv_roll[0]  = pr_roll_r;
  assign cv_pitch[0] = pr_pitch_r;
  assign cv_side[0]  = pr_side_r;

  // ---------------------------------------------------------------------
  // CORDIC chain, one table angle per cell.
  for (genvar i = 0; i < NSTG; i++) begin : g_cordic
    atrp_cordic_cell #(
      .STAGE  (i),
      .SIDE_W (TLT_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (pipe_en),
      .in_valid  (cv_valid[i]),
      .in_roll   (cv_roll[i]),
      .in_pitch  (cv_pitch[i]),
      .in_side   (cv_side[i]),
      .out_valid (cv_valid[i+1]),
      .out_roll  (cv_roll[i+1]),
      .out_pitch (cv_pitch[i+1]),
      .out_side  (cv_side[i+1])
    );
  end

  // ---------------------------------------------------------------------
  // Finish stage 1: clamp, negate roll, substitute pitch for a zero y-z vector.
  atrp_pkg::tilt_side_t  cv_last;
  atrp_pkg::ang_t        f1_roll_nxt;
  atrp_pkg::ang_t        f1_pitch_nxt;
  logic                  f1_valid_r;
  atrp_pkg::ang_t        f1_roll_r;
  atrp_pkg::ang_t        f1_pitch_r;

  assign cv_last = cv_side[NSTG];

  always_comb begin
    f1_roll_nxt = -atrp_pkg::clamp_ang(cv_roll[NSTG].z, atrp_pkg::DEG180);
    if (cv_last.yz_zero) begin
      f1_pitch_nxt = cv_last.ax_pos ? atrp_pkg::DEG90 : -atrp_pkg::DEG90;
    end else begin
      f1_pitch_nxt = atrp_pkg::clamp_ang(cv_pitch[NSTG].z, atrp_pkg::DEG90);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
    end else if (pipe_en) begin
      f1_valid_r <= cv_valid[NSTG];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      f1_roll_r  <= f1_roll_nxt;
      f1_pitch_r <= f1_pitch_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Finish stage 2: round half up to the output fraction bits.
  atrp_pkg::ang_t        roll_sh;
  atrp_pkg::ang_t        pitch_sh;
  atrp_pkg::res_t        f2_res_nxt;
  logic                  f2_valid_r;
  atrp_pkg::res_t        f2_res_r;

  always_comb begin
    roll_sh          = (f1_roll_r + RND) >>> RSH;
    pitch_sh         = (f1_pitch_r + RND) >>> RSH;
    f2_res_nxt.roll  = roll_sh[atrp_pkg::ROLL_W-1:0];
    f2_res_nxt.pitch = pitch_sh[atrp_pkg::PITCH_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f2_valid_r <= 1'b0;
    end else if (pipe_en) begin
      f2_valid_r <= f1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      f2_res_r <= f2_res_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Output register with one skid entry behind it.
  logic                  out_valid_r;
  atrp_pkg::res_t        out_res_r;
  atrp_pkg::res_t        skid_res_r;
  logic                  arrive;
  logic                  out_take;

  assign arrive   = pipe_en && f2_valid_r;
  assign out_take = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_take) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= arrive;
      end
    end else if (arrive) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      out_res_r <= skid_valid_r ? skid_res_r : f2_res_r;
    end
    if (!out_take && arrive) begin
      skid_res_r <= f2_res_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(40 - $bits(atrp_pkg::res_t)){1'b0}}, out_res_r};

`ifndef SYNTH
  // The skid entry is only ever occupied behind a full output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry holds a beat while the output register is empty");

  // The skid entry fills only after a stalled output cycle.
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && !out_tready))
    else $error("skid entry filled without an output stall");

  // The pitch magnitude vector never has a negative x component.
  a_pitch_x_pos: assert property (@(posedge clk) disable iff (!rst_n)
    pr_valid_r |-> !pr_pitch_r.x[CW-1])
    else $error("pitch CORDIC vector starts with negative x");

  // A zero y-z vector leaves the roll angle at zero through the chain.
  a_roll_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (cv_valid[NSTG] && cv_last.yz_zero) |-> (cv_roll[NSTG].z == '0))
    else $error("roll angle moved for a zero y-z vector");

  // Clamped pitch stays within plus or minus 90 degrees.
  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    f1_valid_r |-> (f1_pitch_r <= atrp_pkg::DEG90 && f1_pitch_r >= -atrp_pkg::DEG90))
    else $error("pitch angle outside plus or minus 90 degrees");
`endif

endmodule

// File: tb/tb_accel_tilt_roll_pitch.sv
// Self-checking testbench for the accelerometer tilt block: each beat is predicted and compared.
module tb_accel_tilt_roll_pitch;
  localparam int IN_W     = atrp_pkg::IN_W;
  localparam int ROLL_W   = atrp_pkg::ROLL_W;
  localparam int PITCH_W  = atrp_pkg::PITCH_W;
  localparam int ANG_BITS = atrp_pkg::ANG_BITS;
  localparam int IN_SHIFT = atrp_pkg::IN_SHIFT;
  localparam int TAB_LEN  = atrp_pkg::TAB_LEN;

  localparam int FRAC         = atrp_pkg::ANGLE_FRAC_BITS_DEF;
  localparam int STAGES       = atrp_pkg::CORDIC_STAGES_DEF;
  localparam int RANDOM_BEATS = 1925;
  localparam int CALM_TAIL    = 250;
  localparam int HOLD_AFTER   = 400;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 80;
  localparam int STALL_LIMIT  = 2000;

  localparam longint ONE_DEG   = 64'sd1 <<< ANG_BITS;
  localparam longint DEG90_FX  = 90 * ONE_DEG;
  localparam longint DEG180_FX = 180 * ONE_DEG;

  typedef struct {
    logic signed [IN_W-1:0] ax;
    logic signed [IN_W-1:0] ay;
    logic signed [IN_W-1:0] az;
  } accel_sample_t;

  typedef struct {
    logic [ROLL_W-1:0]  roll;
    logic [PITCH_W-1:0] pitch;
  } tilt_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata   = '0;   // accel_x[15:0], accel_y[31:16], accel_z[47:32]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;         // roll_angle[16:0], pitch_angle[32:17], zeros[39:33]

  // Arctangent of 2^-i in degrees scaled by 2^20.
  longint atan_step [TAB_LEN] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
    234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
    917, 458, 229, 115, 57, 29, 14, 7
  };

  accel_sample_t samples_to_send[$];
  tilt_t         expected_angles[$];
  accel_sample_t beat_on_bus;

  int  error_count    = 0;
  int  results_seen   = 0;
  int  samples_taken  = 0;
  int  backpress_cyc  = 0;
  int  idle_left      = 0;
  int  stall_left     = 0;
  int  hold_left      = 0;
  bit  hold_done      = 1'b0;
  int  quiet_cycles   = 0;
  int  cycle_no       = 0;
  bit  calm           = 1'b0;

  accel_tilt_roll_pitch u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #2 clk = ~clk;

  // Floor of the square root of a 64-bit unsigned value, bit by bit.
  function automatic longint unsigned root_floor(input longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint clamp_deg(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // Vectoring CORDIC: angle of (vx, vy) in degrees * 2^20, kept within +-180.
  function automatic longint vector_angle(input longint vx, input longint vy);
    longint ang;
    longint xs;
    longint ys;
    ang = 0;
    // Left half plane: turn the vector half a circle first.
    if (vx < 0) begin
      ang = (vy >= 0) ? DEG180_FX : -DEG180_FX;
      vx  = -vx;
      vy  = -vy;
    end
    for (int i = 0; i < STAGES && i < TAB_LEN; i++) begin
      xs = vx >>> i;
      ys = vy >>> i;
      if (vy > 0) begin
        vx  = vx + ys;
        vy  = vy - xs;
        ang = ang + atan_step[i];
      end else if (vy < 0) begin
        vx  = vx - ys;
        vy  = vy + xs;
        ang = ang - atan_step[i];
      end
    end
    return clamp_deg(ang, DEG180_FX);
  endfunction

  // Round half up from 20 fraction bits down to the output format.
  function automatic longint round_angle(input longint a);
    int s;
    s = ANG_BITS - FRAC;
    if (s > 0) return (a + (64'sd1 <<< (s - 1))) >>> s;
    return a;
  endfunction

  function automatic tilt_t predict_tilt(input accel_sample_t smp);
    longint          x;
    longint          y;
    longint          z;
    longint          roll;
    longint          pitch;
    longint unsigned sq;
    longint unsigned mag;
    tilt_t           t;
    x = smp.ax;
    y = smp.ay;
    z = smp.az;
    roll = 0;
    if (y != 0 || z != 0) roll = vector_angle(z <<< IN_SHIFT, y <<< IN_SHIFT);
    roll = -roll;
    // With no y/z component the pitch is straight up or down.
    if (y == 0 && z == 0) begin
      pitch = (x > 0) ? DEG90_FX : -DEG90_FX;
    end else begin
      sq    = longint'(y * y + z * z);
      mag   = root_floor(sq << (2 * IN_SHIFT));
      pitch = clamp_deg(vector_angle(longint'(mag), -(x <<< IN_SHIFT)), DEG90_FX);
    end
    t.roll  = ROLL_W'(round_angle(roll));
    t.pitch = PITCH_W'(round_angle(pitch));
    return t;
  endfunction

  task automatic queue_sample(input int x, input int y, input int z);
    accel_sample_t smp;
    smp.ax = IN_W'(x);
    smp.ay = IN_W'(y);
    smp.az = IN_W'(z);
    samples_to_send.push_back(smp);
  endtask

  function automatic int pick_extreme();
    case ($urandom_range(0, 6))
      0:       return -32768;
      1:       return -32767;
      2:       return -1;
      3:       return 0;
      4:       return 1;
      5:       return 32766;
      default: return 32767;
    endcase
  endfunction

  function automatic int near_axis();
    int m;
    m = $urandom_range(12000, 20000);
    return ($urandom_range(0, 1) != 0) ? m : -m;
  endfunction

  // Random triple drawn from a mix of shapes: full range, sensor-like, tiny, extreme and degenerate.
  task automatic queue_random_sample();
    int x;
    int y;
    int z;
    x = int'($signed(16'($urandom)));
    y = int'($signed(16'($urandom)));
    z = int'($signed(16'($urandom)));
    case ($urandom_range(0, 9))
      4, 5: begin
        x = $urandom_range(0, 4000) - 2000;
        y = $urandom_range(0, 4000) - 2000;
        z = $urandom_range(0, 4000) - 2000;
        case ($urandom_range(0, 2))
          0:       x = near_axis();
          1:       y = near_axis();
          default: z = near_axis();
        endcase
      end
      6: begin
        x = $urandom_range(0, 8) - 4;
        y = $urandom_range(0, 8) - 4;
        z = $urandom_range(0, 8) - 4;
      end
      7: begin
        if ($urandom_range(0, 1) != 0) y = 0;
        else z = 0;
      end
      8: begin
        x = pick_extreme();
        y = pick_extreme();
        z = pick_extreme();
      end
      9: begin
        y = 0;
        z = 0;
      end
      default: ;
    endcase
    queue_sample(x, y, z);
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s at result %0d: got %0d, expected %0d", what, results_seen, got, want);
    error_count++;
  endtask

  // Free-running cycle count and the flag that turns idling off near the end.
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    calm     <= (samples_to_send.size() < CALM_TAIL);
  end

  // Input driver: presents queued samples and records the prediction for each accepted beat.
  always @(posedge clk) begin : drive_beats
    logic next_valid;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      idle_left  = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_angles.push_back(predict_tilt(beat_on_bus));
        samples_taken++;
      end
      if (in_tvalid && !in_tready) backpress_cyc++;
      if (!in_tvalid || in_tready) begin
        next_valid = 1'b0;
        if (idle_left > 0) begin
          idle_left--;
        end else if (!calm && cycle_no[9:8] != 2'd0 && $urandom_range(0, 7) == 0) begin
          idle_left = $urandom_range(1, 11) - 1;
        end else if (samples_to_send.size() > 0) begin
          beat_on_bus = samples_to_send.pop_front();
          in_tdata   <= {beat_on_bus.az, beat_on_bus.ay, beat_on_bus.ax};
          next_valid  = 1'b1;
        end
        in_tvalid <= next_valid;
      end
    end
  end

  // Result receiver: random stalls plus one long hold-off that backs the pipeline up.
  always @(posedge clk) begin : accept_results
    logic ready_next;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left  = 0;
      hold_left   = 0;
    end else begin
      if (!hold_done && samples_taken >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      ready_next = 1'b1;
      if (hold_left > 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        ready_next = 1'b0;
      end else if (!calm && cycle_no[9:8] != 2'd1 && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 11) - 1;
        ready_next = 1'b0;
      end
      out_tready <= ready_next;
    end
  end

  // Result checker: each beat against the oldest prediction, field by field.
  always @(posedge clk) begin : check_results
    tilt_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_angles.size() == 0) begin
        report_mismatch("unexpected result beat", longint'(out_tdata), 0);
      end else begin
        want = expected_angles.pop_front();
        if (out_tdata[16:0] !== want.roll)
          report_mismatch("roll_angle", $signed(out_tdata[16:0]), $signed(want.roll));
        if (out_tdata[32:17] !== want.pitch)
          report_mismatch("pitch_angle", $signed(out_tdata[32:17]), $signed(want.pitch));
        if (out_tdata[39:33] !== 7'd0)
          report_mismatch("padding bits", longint'(out_tdata[39:33]), 0);
      end
      results_seen++;
    end
  end

  // Watchdog: too long without any beat on either side ends the run.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d predictions pending",
                 quiet_cycles, expected_angles.size());
        $display("TB_ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    // Directed corners: zero vectors, axis-aligned vectors, the half-circle
    // boundary on negative z, and full-scale values.
    queue_sample(0, 0, 0);
    queue_sample(1, 0, 0);
    queue_sample(-1, 0, 0);
    queue_sample(32767, 0, 0);
    queue_sample(-32768, 0, 0);
    queue_sample(0, 0, 1);
    queue_sample(0, 0, -1);
    queue_sample(0, 1, 0);
    queue_sample(0, -1, 0);
    queue_sample(0, -1, -32768);
    queue_sample(0, 1, -32768);
    queue_sample(0, 32767, -32768);
    queue_sample(0, -32768, -32768);
    queue_sample(-32768, -32768, -32768);
    queue_sample(32767, 32767, 32767);
    queue_sample(32767, 0, 1);
    queue_sample(-32768, 1, 0);
    queue_sample(-32768, 0, -1);
    queue_sample(16384, 0, 16384);
    queue_sample(-16384, -16384, 0);
    queue_sample(0, -32768, 0);
    queue_sample(1, -32768, 32767);
    queue_sample(-1, 1, 1);
    for (int i = 0; i < RANDOM_BEATS; i++) queue_random_sample();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (samples_to_send.size() > 0 || in_tvalid) @(posedge clk);
    while (expected_angles.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d tilt results from %0d accelerometer triples.", results_seen,
             samples_taken);
    $display("Input was held off for %0d cycles, mostly during one long output stall.",
             backpress_cyc);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/atrp_pkg.sv
rtl/atrp_sqrt_cell.sv
rtl/atrp_cordic_cell.sv
rtl/accel_tilt_roll_pitch.sv
tb/tb_accel_tilt_roll_pitch.sv
